// ----- rtl/htp_pkg.sv -----
`timescale 1ns / 1ps

package htp_pkg;

  // Frame geometry defaults
  localparam int MAX_FRAME_BYTES_DEF = 15;
  localparam int FIELD_COUNT_DEF     = 8;
  localparam int OUT_FIELDS          = 8;

  // Config port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int MIN_W      = 4;

  localparam logic [7:0]       HDR1_RST = 8'h2C;
  localparam logic [7:0]       HDR2_RST = 8'h12;
  localparam logic [7:0]       TAIL_RST = 8'h5B;
  localparam logic [MIN_W-1:0] MIN_RST  = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_FIRST  = 4'd0,
    CFG_HEADER_SECOND = 4'd1,
    CFG_TAIL_BYTE     = 4'd2,
    CFG_MIN_DATA      = 4'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]       hdr1;
    logic [7:0]       hdr2;
    logic [7:0]       tail;
    logic [MIN_W-1:0] min_data;
  } cfg_t;

  // One closed frame, as handed from front to back
  typedef struct packed {
    logic                       status;
    logic [OUT_FIELDS-1:0][7:0] fields;
  } rec_t;

  // Status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_SHORT = 1'b1;

  // Record queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

// ----- rtl/htp_if.sv -----
`timescale 1ns / 1ps

interface htp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface htp_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] field_0;
  logic [7:0] field_1;
  logic [7:0] field_2;
  logic [7:0] field_3;
  logic [7:0] field_4;
  logic [7:0] field_5;
  logic [7:0] field_6;
  logic [7:0] field_7;
  logic [7:0] steer_hold;
  modport source (output valid, output status, output field_0, output field_1,
                  output field_2, output field_3, output field_4, output field_5,
                  output field_6, output field_7, output steer_hold, input ready);
  modport sink   (input valid, input status, input field_0, input field_1,
                  input field_2, input field_3, input field_4, input field_5,
                  input field_6, input field_7, input steer_hold, output ready);
endinterface

interface htp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [htp_pkg::CFG_IDX_W-1:0]  index;
  logic [htp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/htp_front.sv -----
`timescale 1ns / 1ps

// Byte parser: header hunt, data collection, close detection.
module htp_front #(
  parameter int MAX_FRAME_BYTES = htp_pkg::MAX_FRAME_BYTES_DEF,
  parameter int FIELD_COUNT     = htp_pkg::FIELD_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  htp_pkg::cfg_t   cfg,
  htp_in_if.sink          in_if,
  input  logic            q_full,
  output logic            push,
  output htp_pkg::rec_t   rec
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES - 1);
  localparam int CMP_W = (CNT_W > htp_pkg::MIN_W) ? CNT_W : htp_pkg::MIN_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAME_BYTES - 2);

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_HDR2 = 4'b0010,
    PH_DATA = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_t;

  phase_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]       hist_r   [FIELD_COUNT];  // hist_r[i]: byte i+1 places back
  logic [7:0]       hist_nxt [FIELD_COUNT];
  logic [7:0]       shifted  [FIELD_COUNT];
  logic [7:0]       b;
  logic             fire, close, accept;
  logic [htp_pkg::OUT_FIELDS-1:0][7:0] fld;

  assign in_if.ready = !q_full;
  assign fire        = in_if.valid && in_if.ready;
  assign b           = in_if.rx_byte;
  assign cnt_inc     = cnt_r + CNT_W'(1);
  assign close       = (state_r == PH_DATA) && ((cnt_inc >= CNT_LIMIT) || (b == cfg.tail));
  // cnt_r is the data count before the final byte
  assign accept      = CMP_W'(cnt_r) >= CMP_W'(cfg.min_data);
  assign push        = fire && close;

  for (genvar j = 0; j < htp_pkg::OUT_FIELDS; j++) begin : g_fld
    if (htp_pkg::OUT_FIELDS - j <= FIELD_COUNT) begin : g_on
      assign fld[j] = accept ? hist_r[htp_pkg::OUT_FIELDS - 1 - j] : 8'h00;
    end else begin : g_off
      assign fld[j] = 8'h00;
    end
  end

  assign rec.status = accept ? htp_pkg::ST_OK : htp_pkg::ST_SHORT;
  assign rec.fields = fld;

  always_comb begin
    shifted[0] = b;
    for (int i = 1; i < FIELD_COUNT; i++) begin
      shifted[i] = hist_r[i-1];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    hist_nxt  = hist_r;
    if (fire) begin
      case (state_r)
        PH_HUNT: begin
          if (b == cfg.hdr1) begin
            for (int i = 0; i < FIELD_COUNT; i++) begin
              hist_nxt[i] = 8'h00;
            end
            hist_nxt[0] = b;
            cnt_nxt     = '0;
            state_nxt   = PH_HDR2;
          end
        end
        PH_HDR2: begin
          if (b == cfg.hdr2) begin
            hist_nxt  = shifted;
            state_nxt = PH_DATA;
          end else begin
            cnt_nxt   = '0;
            state_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          hist_nxt = shifted;
          cnt_nxt  = cnt_inc;
          if (close) begin
            state_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          cnt_nxt   = '0;
          state_nxt = PH_HUNT;
        end
        default: begin
          cnt_nxt   = '0;
          state_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_HUNT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    hist_r <= hist_nxt;
  end

  // every close leaves exactly one byte to drop
  a_close_skip: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> state_r == PH_SKIP)
    else $error("close not followed by skip phase");

endmodule

// ----- rtl/htp_queue.sv -----
`timescale 1ns / 1ps

// Two-entry record queue between parser and output stage.
module htp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  htp_pkg::rec_t push_rec,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output htp_pkg::rec_t pop_rec
);

  htp_pkg::rec_t                    mem_r [htp_pkg::Q_DEPTH];
  logic [htp_pkg::Q_PTR_W-1:0]      wr_r, rd_r;
  logic [htp_pkg::Q_CNT_W-1:0]      cnt_r, cnt_nxt;

  assign full    = cnt_r == htp_pkg::Q_CNT_W'(htp_pkg::Q_DEPTH);
  assign avail   = cnt_r != '0;
  assign pop_rec = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + htp_pkg::Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - htp_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + htp_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + htp_pkg::Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_r] <= push_rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> avail)
    else $error("pop from empty queue");

endmodule

// ----- rtl/htp_back.sv -----
`timescale 1ns / 1ps

// Output stage: steering hold update and result register.
module htp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          avail,
  input  htp_pkg::rec_t rec,
  output logic          pop,
  htp_out_if.source     out_if
);

  htp_pkg::rec_t data_r;
  logic          valid_r;
  logic [7:0]    held_r, held_nxt, steer_r;

  assign pop = avail && (!valid_r || out_if.ready);

  // field 1 of an accepted frame steers when nonzero
  assign held_nxt = ((rec.status == htp_pkg::ST_OK) && (rec.fields[1] != 8'h00)) ?
                    rec.fields[1] : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      held_r  <= 8'h00;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
        held_r  <= held_nxt;
      end else if (out_if.ready) begin
        valid_r <= 1'b0;
      end
    end
    if (pop) begin
      data_r  <= rec;
      steer_r <= held_nxt;
    end
  end

  assign out_if.valid      = valid_r;
  assign out_if.status     = data_r.status;
  assign out_if.field_0    = data_r.fields[0];
  assign out_if.field_1    = data_r.fields[1];
  assign out_if.field_2    = data_r.fields[2];
  assign out_if.field_3    = data_r.fields[3];
  assign out_if.field_4    = data_r.fields[4];
  assign out_if.field_5    = data_r.fields[5];
  assign out_if.field_6    = data_r.fields[6];
  assign out_if.field_7    = data_r.fields[7];
  assign out_if.steer_hold = steer_r;

  a_held_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> $stable(held_r))
    else $error("steering hold moved without a result");

endmodule

// ----- rtl/header_tail_frame_field_parser_core.sv -----
`timescale 1ns / 1ps

// Two-byte-header frame parser for a received byte stream.
//
// in_if   : one rx_byte per item. Bytes are matched against header_first,
//           then header_second, then collected until tail_byte or the
//           frame length limit (MAX_FRAME_BYTES - 2 data bytes) closes it.
// out_if  : one item per closed frame: status (0 ok, 1 too short), the
//           eight bytes before the closing byte (field_0 oldest, zero if too short) and the
//           held steering value. The byte after a close is always dropped.
// cfg_if  : register writes (0 header_first, 1 header_second, 2 tail_byte,
//           3 min_data_bytes); other indexes are ignored. Always ready;
//           write only while no frame is in flight.
// Rate    : one byte per cycle while in_if ready is high. A result reaches
//           out_if by way of the record queue entry, then the output
//           register.
// Stall   : when out_if stalls, closed frames collect in the queue; in_if
//           ready drops only once the queue holds two records.
// Reset   : synchronous, active low; registers return to their defaults,
//           the parser hunts for a header and the steering hold is zero.
module header_tail_frame_field_parser_core #(
  parameter int MAX_FRAME_BYTES = htp_pkg::MAX_FRAME_BYTES_DEF,
  parameter int FIELD_COUNT     = htp_pkg::FIELD_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  htp_in_if.sink     in_if,
  htp_out_if.source  out_if,
  htp_cfg_if.sink    cfg_if
);

  htp_pkg::cfg_t cfg_r;
  htp_pkg::rec_t push_rec, pop_rec;
  logic          push, pop, q_full, q_avail;

  // Config registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdr1     <= htp_pkg::HDR1_RST;
      cfg_r.hdr2     <= htp_pkg::HDR2_RST;
      cfg_r.tail     <= htp_pkg::TAIL_RST;
      cfg_r.min_data <= htp_pkg::MIN_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (htp_pkg::cfg_idx_t'(cfg_if.index))
        htp_pkg::CFG_HEADER_FIRST:  cfg_r.hdr1     <= cfg_if.data[7:0];
        htp_pkg::CFG_HEADER_SECOND: cfg_r.hdr2     <= cfg_if.data[7:0];
        htp_pkg::CFG_TAIL_BYTE:     cfg_r.tail     <= cfg_if.data[7:0];
        htp_pkg::CFG_MIN_DATA:      cfg_r.min_data <= cfg_if.data[htp_pkg::MIN_W-1:0];
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // Front: parse and classify bytes
  htp_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .FIELD_COUNT     (FIELD_COUNT)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_if  (in_if),
    .q_full (q_full),
    .push   (push),
    .rec    (push_rec)
  );

  // Closed-frame records waiting for the output stage
  htp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .avail    (q_avail),
    .pop_rec  (pop_rec)
  );

  // Back: steering hold and result register
  htp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .avail  (q_avail),
    .rec    (pop_rec),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule
